// ===== rtl/core/clws_pkg.sv =====
// Shared types and constants for the character LCD write sequencer.
// No dependencies; imported by every module of the core.
package clws_pkg;

    // Request codes
    typedef enum logic [2:0] {
        CMD_CHAR     = 3'd0,
        CMD_RAW      = 3'd1,
        CMD_POSITION = 3'd2,
        CMD_CLEAR    = 3'd3,
        CMD_HOME     = 3'd4,
        CMD_DISPLAY  = 3'd5,
        CMD_CURSOR   = 3'd6,
        CMD_BLINK    = 3'd7
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_COLUMNS     = 2'd0,
        CFG_ROWS_IN_USE = 2'd1,
        CFG_BUS_IS_8BIT = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    localparam int unsigned CfgDataW = 6;

    // Controller command bytes and settle times
    localparam logic [7:0] LcdClear     = 8'h01;
    localparam logic [7:0] LcdHome      = 8'h02;
    localparam logic [7:0] LcdCtrlBase  = 8'h08;
    localparam logic [2:0] FlagDisplay  = 3'h4;
    localparam logic [2:0] FlagCursor   = 3'h2;
    localparam logic [2:0] FlagBlink    = 3'h1;
    localparam logic [3:0] NibbleMask   = 4'hF;
    localparam logic [2:0] WaitNone     = 3'd0;
    localparam logic [2:0] WaitCmd      = 3'd2;
    localparam logic [2:0] WaitHome     = 3'd7;

    // Job queue depth
    localparam int unsigned QDepth = 4;
    localparam int unsigned QPtrW  = $clog2(QDepth);

    // One byte to put on the bus
    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        logic [2:0] wait_ms;
    } t_byte_op;

    // One classified request: one or two bytes
    typedef struct packed {
        logic     two;
        t_byte_op b0;
        t_byte_op b1;
    } t_job;

    // One enable strobe
    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        logic [2:0] wait_ms;
        logic       last;
    } t_strobe;

    // Set-address command: 0x80 | row bit at 0x40 | column
    function automatic logic [7:0] addr_cmd(input logic row, input logic [5:0] col);
        addr_cmd = {1'b1, row, col};
    endfunction

endpackage

// ===== rtl/core/char_lcd_write_sequencer_core.sv =====
// Character LCD write sequencer: top level with config registers.
// Depends on clws_pkg, clws_front, clws_queue, clws_back.
//
// Turns display requests into enable strobes for a character LCD on a 4-bit or
// 8-bit parallel bus. Requests enter through a queue-style port (push/full) and
// strobes leave through another (empty/pop); each strobe carries register
// select, bus data (nibble in bits 3..0 in 4-bit mode), the settle time in ms
// the driver must wait after it, and a last flag marking the final strobe of a
// request. A request yields one to four strobes: one byte (two nibbles in
// 4-bit mode), or two bytes for a clear and for a character that wraps the
// cursor, which re-issues the set-address command. A position request outside
// the configured columns/rows is dropped with no strobe. The front end updates
// cursor and control flags as each request is accepted, one per cycle while
// the queue is not full, and pushes a byte job into a four-entry queue; the
// back end emits one strobe per cycle into the result register while a job
// is queued and the register is empty or being popped. An accepted request is
// written into the queue and reaches the result ports through the result
// register. Config writes (index 0 columns, 1 rows in use, 2 bus width) are
// always ready and must only be made while no request is in flight.
module char_lcd_write_sequencer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request side
    input  logic                        push,
    output logic                        full,
    input  logic [2:0]                  i_cmd,
    input  logic [7:0]                  i_value,
    input  logic [5:0]                  i_column,
    input  logic [1:0]                  i_row_index,
    // strobe side
    output logic                        empty,
    input  logic                        pop,
    output logic                        o_register_select,
    output logic [7:0]                  o_bus_data,
    output logic [2:0]                  o_extra_wait_ms,
    output logic                        o_last,
    // config write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [clws_pkg::CfgDataW-1:0] i_cfg_data
);
    import clws_pkg::*;

    logic [5:0] r_columns;
    logic [1:0] r_rows_in_use;
    logic       r_bus_is_8bit;

    logic       accept;
    logic       job_valid;
    t_job       front_job, q_job;
    logic       q_full, q_empty, q_pop;
    t_strobe    strobe;

    // Config registers; reset to 16 columns, 2 rows, 4-bit bus
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns     <= 6'd16;
            r_rows_in_use <= 2'd2;
            r_bus_is_8bit <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_COLUMNS:     r_columns     <= i_cfg_data[5:0];
                CFG_ROWS_IN_USE: r_rows_in_use <= i_cfg_data[1:0];
                CFG_BUS_IS_8BIT: r_bus_is_8bit <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Requests are taken whenever the job queue has room
    assign full   = q_full;
    assign accept = push && !q_full;

    clws_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_cmd         (i_cmd),
        .i_value       (i_value),
        .i_column      (i_column),
        .i_row_index   (i_row_index),
        .i_columns     (r_columns),
        .i_rows_in_use (r_rows_in_use),
        .o_job_valid   (job_valid),
        .o_job         (front_job)
    );

    // Rejected positions push nothing
    clws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && job_valid),
        .i_data  (front_job),
        .i_pop   (q_pop),
        .o_data  (q_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    clws_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bus_is_8bit (r_bus_is_8bit),
        .i_job_empty   (q_empty),
        .i_job         (q_job),
        .o_job_pop     (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_strobe      (strobe)
    );

    assign o_register_select = strobe.rs;
    assign o_bus_data        = strobe.data;
    assign o_extra_wait_ms   = strobe.wait_ms;
    assign o_last            = strobe.last;

endmodule

// ===== rtl/core/clws_front.sv =====
// Front end: accepts requests, tracks cursor and control flags, emits byte jobs.
// Depends on clws_pkg.
module clws_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [2:0]          i_cmd,
    input  logic [7:0]          i_value,
    input  logic [5:0]          i_column,
    input  logic [1:0]          i_row_index,
    input  logic [5:0]          i_columns,
    input  logic [1:0]          i_rows_in_use,
    output logic                o_job_valid,
    output clws_pkg::t_job      o_job
);
    import clws_pkg::*;

    logic [5:0] r_col, n_col;
    logic       r_row, n_row;
    logic [2:0] r_flags, n_flags;

    logic [5:0] inc_col;
    logic [1:0] inc_row;
    logic       wrap_row;
    logic [2:0] flag_bit;
    logic       pos_ok;
    t_cmd       cmd;

    assign cmd      = t_cmd'(i_cmd);
    assign inc_col  = r_col + 6'd1;
    assign inc_row  = {1'b0, r_row} + 2'd1;
    assign wrap_row = (inc_row == i_rows_in_use) || (inc_row > 2'd1) ? 1'b0 : inc_row[0];
    assign pos_ok   = (i_column < i_columns) && (i_row_index < i_rows_in_use)
                      && (i_row_index <= 2'd1);

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_flags     = r_flags;
        o_job_valid = 1'b1;
        o_job       = '0;
        flag_bit    = FlagBlink;
        unique case (cmd)
            CMD_CHAR: begin
                o_job.b0 = '{rs: 1'b1, data: i_value, wait_ms: WaitNone};
                if (inc_col == i_columns) begin
                    n_col    = '0;
                    n_row    = wrap_row;
                    o_job.two = 1'b1;
                    o_job.b1 = '{rs: 1'b0, data: addr_cmd(wrap_row, 6'd0), wait_ms: WaitCmd};
                end else begin
                    n_col = inc_col;
                end
            end
            CMD_RAW: begin
                o_job.b0 = '{rs: 1'b0, data: i_value, wait_ms: WaitCmd};
            end
            CMD_POSITION: begin
                o_job_valid = pos_ok;
                o_job.b0 = '{rs: 1'b0, data: addr_cmd(i_row_index[0], i_column),
                             wait_ms: WaitCmd};
                if (pos_ok) begin
                    n_col = i_column;
                    n_row = i_row_index[0];
                end
            end
            CMD_CLEAR: begin
                o_job.two = 1'b1;
                o_job.b0  = '{rs: 1'b0, data: LcdClear, wait_ms: WaitCmd};
                o_job.b1  = '{rs: 1'b0, data: LcdHome, wait_ms: WaitHome};
                n_col     = '0;
                n_row     = 1'b0;
            end
            CMD_HOME: begin
                o_job.b0 = '{rs: 1'b0, data: LcdHome, wait_ms: WaitHome};
                n_col    = '0;
                n_row    = 1'b0;
            end
            CMD_DISPLAY, CMD_CURSOR, CMD_BLINK: begin
                if (cmd == CMD_DISPLAY) begin
                    flag_bit = FlagDisplay;
                end else if (cmd == CMD_CURSOR) begin
                    flag_bit = FlagCursor;
                end
                n_flags  = i_value[0] ? (r_flags | flag_bit) : (r_flags & ~flag_bit);
                o_job.b0 = '{rs: 1'b0, data: LcdCtrlBase | {5'd0, n_flags}, wait_ms: WaitCmd};
            end
            default: begin
                o_job_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= 1'b0;
            r_flags <= '0;
        end else if (i_accept) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_flags <= n_flags;
        end
    end

endmodule

// ===== rtl/core/clws_queue.sv =====
// Small job queue between front end and strobe sequencer.
// Depends on clws_pkg.
module clws_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  clws_pkg::t_job      i_data,
    input  logic                i_pop,
    output clws_pkg::t_job      o_data,
    output logic                o_full,
    output logic                o_empty
);
    import clws_pkg::*;

    t_job              r_mem [QDepth];
    logic [QPtrW-1:0]  r_wr, r_rd;
    logic [QPtrW:0]    r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == (QPtrW+1)'(QDepth));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QPtrW+1)'(do_push) - (QPtrW+1)'(do_pop);
        end
    end

endmodule

// ===== rtl/core/clws_back.sv =====
// Back end: splits queued byte jobs into enable strobes, holds the result register.
// Depends on clws_pkg.
module clws_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_bus_is_8bit,
    input  logic                i_job_empty,
    input  clws_pkg::t_job      i_job,
    output logic                o_job_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output clws_pkg::t_strobe   o_strobe
);
    import clws_pkg::*;

    typedef enum logic [3:0] {
        ST_B0_HI = 4'b0001,
        ST_B0_LO = 4'b0010,
        ST_B1_HI = 4'b0100,
        ST_B1_LO = 4'b1000
    } t_step;

    t_step     r_step, n_step;
    logic      r_out_valid;
    t_strobe   r_out, n_out;
    logic      can_load, emit, job_done;
    t_byte_op  cur;
    logic      second, low_half;

    assign can_load = !r_out_valid || i_pop;
    assign emit     = can_load && !i_job_empty;
    assign second   = (r_step == ST_B1_HI) || (r_step == ST_B1_LO);
    assign low_half = (r_step == ST_B0_LO) || (r_step == ST_B1_LO);
    assign cur      = second ? i_job.b1 : i_job.b0;

    always_comb begin
        n_step   = r_step;
        job_done = 1'b0;
        unique case (r_step)
            ST_B0_HI: begin
                if (!i_bus_is_8bit) begin
                    n_step = ST_B0_LO;
                end else if (i_job.two) begin
                    n_step = ST_B1_HI;
                end else begin
                    job_done = 1'b1;
                end
            end
            ST_B0_LO: begin
                if (i_job.two) begin
                    n_step = ST_B1_HI;
                end else begin
                    n_step   = ST_B0_HI;
                    job_done = 1'b1;
                end
            end
            ST_B1_HI: begin
                if (!i_bus_is_8bit) begin
                    n_step = ST_B1_LO;
                end else begin
                    n_step   = ST_B0_HI;
                    job_done = 1'b1;
                end
            end
            ST_B1_LO: begin
                n_step   = ST_B0_HI;
                job_done = 1'b1;
            end
            default: begin
                n_step = ST_B0_HI;
            end
        endcase
    end

    // Nibble strobes: high half carries no settle time
    always_comb begin
        n_out.rs   = cur.rs;
        n_out.last = job_done;
        if (i_bus_is_8bit) begin
            n_out.data    = cur.data;
            n_out.wait_ms = cur.wait_ms;
        end else if (low_half) begin
            n_out.data    = {4'd0, cur.data[3:0] & NibbleMask};
            n_out.wait_ms = cur.wait_ms;
        end else begin
            n_out.data    = {4'd0, cur.data[7:4]};
            n_out.wait_ms = WaitNone;
        end
    end

    assign o_job_pop = emit && job_done;
    assign o_empty   = !r_out_valid;
    assign o_strobe  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_B0_HI;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) r_step <= n_step;
            if (can_load) r_out_valid <= !i_job_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) r_out <= n_out;
    end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for char_lcd_write_sequencer_core: random and directed
// requests in, strobes checked against an in-bench model. Depends on clws_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import clws_pkg::*;

    localparam int unsigned SettleCycles = 8;     // lets the job queue and result register drain
    localparam int unsigned QuietLimit   = 1000;  // cycles with no handshake at all
    localparam logic [7:0]  AddrBase     = 8'h80;
    localparam logic [7:0]  Row1Offset   = 8'h40;

    typedef struct {
        t_cmd       cmd;
        logic [7:0] value;
        logic [5:0] column;
        logic [1:0] row_index;
    } t_lcd_request;

    // ---------------------------------------------------------------- DUT ports
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [2:0] i_cmd = '0;
    logic [7:0] i_value = '0;
    logic [5:0] i_column = '0;
    logic [1:0] i_row_index = '0;
    logic       empty;
    logic       pop = 1'b0;
    logic       o_register_select;
    logic [7:0] o_bus_data;
    logic [2:0] o_extra_wait_ms;
    logic       o_last;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    char_lcd_write_sequencer_core u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_cmd             (i_cmd),
        .i_value           (i_value),
        .i_column          (i_column),
        .i_row_index       (i_row_index),
        .empty             (empty),
        .pop               (pop),
        .o_register_select (o_register_select),
        .o_bus_data        (o_bus_data),
        .o_extra_wait_ms   (o_extra_wait_ms),
        .o_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- bench state
    t_lcd_request pending_requests[$];   // requests not yet taken by the block
    t_strobe      expected_strobes[$];   // strobes owed by accepted requests
    int           idle_pct = 34;         // chance per cycle that a side holds off
    int           errors = 0;
    int           quiet_cycles = 0;
    bit           req_fired = 1'b0;      // request taken at the last rising edge
    t_strobe      want;

    // Display model: configuration and cursor/flag state
    logic [5:0] lcd_columns;
    logic [1:0] lcd_rows;
    logic       lcd_bus8;
    logic [5:0] cursor_col;
    logic       cursor_row;
    logic [2:0] ctrl_flags;

    // Queue one byte as one strobe (8-bit bus) or two nibble strobes.
    function automatic void queue_byte(logic sel, logic [7:0] byte_val, logic [2:0] settle);
        if (lcd_bus8) begin
            expected_strobes.push_back('{rs: sel, data: byte_val, wait_ms: settle, last: 1'b0});
        end else begin
            expected_strobes.push_back('{rs: sel, data: {4'h0, byte_val[7:4]},
                                         wait_ms: WaitNone, last: 1'b0});
            expected_strobes.push_back('{rs: sel, data: {4'h0, byte_val[3:0]},
                                         wait_ms: settle, last: 1'b0});
        end
    endfunction

    function automatic logic [7:0] set_address(logic row, logic [5:0] col);
        return (AddrBase | (row ? Row1Offset : 8'h00)) + {2'b00, col};
    endfunction

    // Work out the strobes of one accepted request and advance the cursor/flags.
    function automatic void predict_strobes(t_lcd_request r);
        int         prior_count = expected_strobes.size();
        logic [5:0] next_col;
        logic [1:0] next_row;
        logic [2:0] flag_bit;
        case (r.cmd)
            CMD_CHAR: begin
                queue_byte(1'b1, r.value, WaitNone);
                next_col = cursor_col + 6'd1;
                if (next_col == lcd_columns) begin
                    // end of line: wrap row, then re-issue the address command
                    next_row   = {1'b0, cursor_row} + 2'd1;
                    cursor_col = '0;
                    cursor_row = (next_row == lcd_rows || next_row > 2'd1) ? 1'b0 : next_row[0];
                    queue_byte(1'b0, set_address(cursor_row, cursor_col), WaitCmd);
                end else begin
                    cursor_col = next_col;
                end
            end
            CMD_RAW: queue_byte(1'b0, r.value, WaitCmd);
            CMD_POSITION: begin
                // out-of-range targets are dropped silently
                if (!(r.column >= lcd_columns || r.row_index >= lcd_rows ||
                      r.row_index > 2'd1)) begin
                    queue_byte(1'b0, set_address(r.row_index[0], r.column), WaitCmd);
                    cursor_col = r.column;
                    cursor_row = r.row_index[0];
                end
            end
            CMD_CLEAR: begin
                queue_byte(1'b0, LcdClear, WaitCmd);
                queue_byte(1'b0, LcdHome, WaitHome);
                cursor_col = '0;
                cursor_row = 1'b0;
            end
            CMD_HOME: begin
                queue_byte(1'b0, LcdHome, WaitHome);
                cursor_col = '0;
                cursor_row = 1'b0;
            end
            default: begin
                flag_bit = (r.cmd == CMD_DISPLAY) ? FlagDisplay :
                           (r.cmd == CMD_CURSOR)  ? FlagCursor  : FlagBlink;
                ctrl_flags = r.value[0] ? (ctrl_flags | flag_bit) : (ctrl_flags & ~flag_bit);
                queue_byte(1'b0, LcdCtrlBase | {5'b0, ctrl_flags}, WaitCmd);
            end
        endcase
        if (expected_strobes.size() > prior_count)
            expected_strobes[expected_strobes.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------- driver
    // Inputs move on the falling edge; a request stays up until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            pop  <= 1'b0;
        end else begin
            if (!(push && !req_fired)) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    push        <= 1'b1;
                    i_cmd       <= pending_requests[0].cmd;
                    i_value     <= pending_requests[0].value;
                    i_column    <= pending_requests[0].column;
                    i_row_index <= pending_requests[0].row_index;
                end else begin
                    push <= 1'b0;
                end
            end
            pop <= ($urandom_range(99) >= idle_pct);
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        req_fired = i_rst_n && push && !full;
        if (req_fired) begin
            predict_strobes(pending_requests.pop_front());
        end

        if (i_rst_n && pop && !empty) begin
            if (expected_strobes.size() == 0) begin
                $error("strobe with no request waiting: rs %0b data %0h wait %0d last %0b",
                       o_register_select, o_bus_data, o_extra_wait_ms, o_last);
                errors++;
            end else begin
                want = expected_strobes.pop_front();
                if (o_register_select !== want.rs) begin
                    $error("register_select: expected %0b, got %0b", want.rs, o_register_select);
                    errors++;
                end
                if (o_bus_data !== want.data) begin
                    $error("bus_data: expected %0h, got %0h", want.data, o_bus_data);
                    errors++;
                end
                if (o_extra_wait_ms !== want.wait_ms) begin
                    $error("extra_wait_ms: expected %0d, got %0d", want.wait_ms, o_extra_wait_ms);
                    errors++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    errors++;
                end
            end
        end

        // watchdog: any handshake counts as progress
        if (req_fired || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    function automatic void add_request(t_cmd cmd, logic [7:0] value,
                                        logic [5:0] column, logic [1:0] row_index);
        t_lcd_request r;
        r.cmd       = cmd;
        r.value     = value;
        r.column    = column;
        r.row_index = row_index;
        pending_requests.push_back(r);
    endfunction

    // One register write; valid is left high for a following write.
    task automatic cfg_write(t_cfg_idx idx, logic [CfgDataW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_COLUMNS:     lcd_columns = data[5:0];
            CFG_ROWS_IN_USE: lcd_rows    = data[1:0];
            CFG_BUS_IS_8BIT: lcd_bus8    = data[0];
            default: ;
        endcase
    endtask

    task automatic set_display(logic [5:0] cols, logic [1:0] rows, logic bus8);
        cfg_write(CFG_UNUSED, CfgDataW'($urandom));
        cfg_write(CFG_COLUMNS, cols);
        cfg_write(CFG_ROWS_IN_USE, {4'b0, rows});
        cfg_write(CFG_BUS_IS_8BIT, {5'b0, bus8});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every request is taken and every strobe seen, then let the
    // pipeline settle: a dropped position request leaves nothing to wait on.
    task automatic drain();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || expected_strobes.size() != 0);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    // Random phase: mostly characters and in-range positions, so the cursor
    // wraps often; the rest spread over the other commands and bad positions.
    task automatic run_random(logic [5:0] cols, logic [1:0] rows, logic bus8,
                              int pct, int count);
        int         pick;
        int         row_lim;
        t_cmd       cmd;
        logic [5:0] col;
        logic [1:0] row;
        set_display(cols, rows, bus8);
        idle_pct = pct;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            col  = 6'($urandom);
            row  = 2'($urandom);
            if (pick < 45)      cmd = CMD_CHAR;
            else if (pick < 65) cmd = CMD_POSITION;
            else if (pick < 75) cmd = CMD_RAW;
            else                cmd = t_cmd'($urandom_range(CMD_CLEAR, CMD_BLINK));
            row_lim = (lcd_rows > 2'd2) ? 2 : int'(lcd_rows);
            if (cmd == CMD_POSITION && lcd_columns != 0 && row_lim != 0 &&
                $urandom_range(3) != 0) begin
                col = 6'($urandom_range(0, lcd_columns - 1));
                row = 2'($urandom_range(0, row_lim - 1));
            end
            add_request(cmd, 8'($urandom), col, row);
        end
        drain();
    endtask

    initial begin
        // reset-state display: 16 columns, 2 rows, 4-bit bus, cursor home
        lcd_columns = 6'd16;
        lcd_rows    = 2'd2;
        lcd_bus8    = 1'b0;
        cursor_col  = '0;
        cursor_row  = 1'b0;
        ctrl_flags  = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: value extremes, every command, flag on/off
        add_request(CMD_CHAR, 8'h00, 6'd0, 2'd0);
        add_request(CMD_CHAR, 8'hFF, 6'd63, 2'd3);
        add_request(CMD_RAW, 8'h00, 6'd0, 2'd0);
        add_request(CMD_RAW, 8'hFF, 6'd0, 2'd0);
        add_request(CMD_DISPLAY, 8'h01, 6'd0, 2'd0);
        add_request(CMD_CURSOR, 8'hFF, 6'd0, 2'd0);
        add_request(CMD_BLINK, 8'h01, 6'd0, 2'd0);
        add_request(CMD_BLINK, 8'hFE, 6'd0, 2'd0);
        add_request(CMD_DISPLAY, 8'h00, 6'd0, 2'd0);
        // positions: last legal cell, then column, row and double rejects
        add_request(CMD_POSITION, 8'h00, 6'd15, 2'd1);
        add_request(CMD_POSITION, 8'h00, 6'd16, 2'd0);
        add_request(CMD_POSITION, 8'h00, 6'd0, 2'd2);
        add_request(CMD_POSITION, 8'h00, 6'd63, 2'd3);
        // column wrap into row 1, then row wrap back to row 0
        add_request(CMD_POSITION, 8'h00, 6'd15, 2'd0);
        add_request(CMD_CHAR, 8'h5A, 6'd0, 2'd0);
        add_request(CMD_POSITION, 8'h00, 6'd15, 2'd1);
        add_request(CMD_CHAR, 8'hA5, 6'd0, 2'd0);
        add_request(CMD_CLEAR, 8'h00, 6'd0, 2'd0);
        add_request(CMD_HOME, 8'hFF, 6'd0, 2'd0);
        drain();

        // columns 0 wraps only past column 63; row 1 + 1 wraps with 3 rows
        set_display(6'd63, 2'd2, 1'b0);
        add_request(CMD_POSITION, 8'h00, 6'd62, 2'd1);
        drain();
        set_display(6'd0, 2'd3, 1'b1);
        add_request(CMD_CHAR, 8'h31, 6'd0, 2'd0);
        add_request(CMD_CHAR, 8'h32, 6'd0, 2'd0);
        add_request(CMD_CHAR, 8'h33, 6'd0, 2'd0);
        add_request(CMD_POSITION, 8'h00, 6'd0, 2'd0);
        drain();

        // random phases over narrow, widest and odd settings; one without idling
        run_random(6'($urandom_range(1, 8)), 2'd2, 1'b0, 34, 21);
        run_random(6'd40, 2'd1, 1'b1, 0, 21);
        run_random(6'd1, 2'd2, 1'b0, 34, 21);
        run_random(6'($urandom_range(0, 63)), 2'($urandom), 1'($urandom), 34, 21);
        run_random(6'd16, 2'd2, 1'b0, 34, 21);

        if (errors == 0 && expected_strobes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== char_lcd_write_sequencer_core.f =====
rtl/core/clws_pkg.sv
rtl/core/clws_front.sv
rtl/core/clws_queue.sv
rtl/core/clws_back.sv
rtl/core/char_lcd_write_sequencer_core.sv
dv/testbench.sv
